/* hw/rtl/mbps_pkg.sv */
package mbps_pkg;

  // default sizing
  localparam int MAX_PATTERN_DEF = 32;
  localparam int COUNT_WIDTH_DEF = 32;

  // fixed field widths
  localparam int LEN_W    = 6;
  localparam int IDX_W    = 5;
  localparam int BYTE_W   = 8;
  localparam int OFFSET_W = 32;

  // request codes
  localparam logic REQ_PATTERN = 1'b0;
  localparam logic REQ_BYTE    = 1'b1;

  typedef struct packed {
    logic [BYTE_W-1:0] mask;
    logic [BYTE_W-1:0] value;
  } entry_t;

  // per-cell control
  typedef struct packed {
    logic win_shift;  // take neighbor's byte
    logic pat_shift;  // take neighbor's entry (reload)
    logic pat_we;     // direct entry write
  } cell_ctrl_t;

  typedef enum logic {
    ST_RUN,
    ST_LOAD
  } mbps_state_e;

endpackage

/* hw/rtl/mbps_ram.sv */
module mbps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/mbps_cell.sv */
// One window position: holds a buffer byte and the pattern entry lined up with it.
module mbps_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mbps_pkg::cell_ctrl_t       ctrl_i,
  input  logic [mbps_pkg::BYTE_W-1:0] win_i,
  input  mbps_pkg::entry_t           pat_i,
  input  mbps_pkg::entry_t           pat_wdata_i,
  output logic [mbps_pkg::BYTE_W-1:0] win_o,
  output mbps_pkg::entry_t           pat_o,
  output logic                       hit_o
);

  logic [mbps_pkg::BYTE_W-1:0] win_q, win_d;
  mbps_pkg::entry_t            pat_q, pat_d;

  always_comb begin
    win_d = ctrl_i.win_shift ? win_i : win_q;
    pat_d = pat_q;
    if (ctrl_i.pat_shift) begin
      pat_d = pat_i;
    end else if (ctrl_i.pat_we) begin
      pat_d = pat_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q <= '0;
    end else begin
      pat_q <= pat_d;
    end
  end

  // compare against the byte this cell holds after a shift
  assign hit_o = ((win_i & pat_q.mask) == pat_q.value);
  assign win_o = win_q;
  assign pat_o = pat_q;

endmodule

/* hw/rtl/masked_byte_pattern_search.sv */
// Masked byte pattern search.
// Input channel (in_valid_i / in_stall_o): req_type_i = REQ_PATTERN writes
// pattern entry pattern_index_i (mask and value); REQ_BYTE streams one buffer
// byte in data_byte_i, last_byte_i marking the end of the buffer.
// Output channel (out_valid_o / out_stall_i): at most one transaction per
// buffer: found_o = 1 with match_offset_o at the first complete match, or
// found_o = 0 with offset 0 on the last byte when nothing matched.
// Throughput: one input transaction per cycle. A result appears in the
// output register the cycle after the byte that causes it is accepted.
// The output register separates the sides; input stalls only while a result
// is held by out_stall_i, or while the pattern row reloads.
// A write to pattern_length (cfg_we_i) starts a reload of the cell row from
// the entry RAM, one entry per cycle through its read port; in_stall_o stays
// high from the write until the reload is done.
// Reset clears the pattern to zero, sets pattern_length to 1 and starts a
// fresh buffer; the entry RAM is covered by per-entry valid bits.
module masked_byte_pattern_search #(
  parameter int MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEF,
  parameter int COUNT_WIDTH = mbps_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [mbps_pkg::LEN_W-1:0]    cfg_wdata_i,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          req_type_i,
  input  logic [mbps_pkg::IDX_W-1:0]    pattern_index_i,
  input  logic [mbps_pkg::BYTE_W-1:0]   pattern_mask_i,
  input  logic [mbps_pkg::BYTE_W-1:0]   pattern_value_i,
  input  logic [mbps_pkg::BYTE_W-1:0]   data_byte_i,
  input  logic                          last_byte_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          found_o,
  output logic [mbps_pkg::OFFSET_W-1:0] match_offset_o
);

  localparam int LW   = $clog2(MAX_PATTERN + 1);
  localparam int AW   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int SW   = $clog2(MAX_PATTERN + 32);
  localparam int CMPW = (COUNT_WIDTH > LW) ? COUNT_WIDTH : LW;
  localparam int EW   = 2 * mbps_pkg::BYTE_W;

  // Row layout: cell m holds the byte of age MAX_PATTERN-1-m (new bytes
  // enter at the top cell) and pattern entry m - off, off = MAX_PATTERN - len.
  // Only cells m >= off take part in the match.

  mbps_pkg::mbps_state_e state_q, state_d;

  logic [mbps_pkg::LEN_W-1:0] len_q;
  logic [LW-1:0]              len_eff;
  logic [LW-1:0]              off;

  logic [LW-1:0]              ld_cnt_q, ld_cnt_d;
  logic                       ld_pend_q;
  logic                       ld_use_q;
  logic                       ld_issue;
  logic                       ld_in_win;
  logic                       ent_vld_rd_q;
  logic [MAX_PATTERN-1:0]     ent_vld_q;

  logic [COUNT_WIDTH-1:0]     count_q, count_d, cnt_inc;
  logic                       done_q, done_d;

  logic                       out_valid_q, out_valid_d;
  logic                       found_q, found_d;
  logic [mbps_pkg::OFFSET_W-1:0] offset_q, offset_d;

  logic in_acc, pat_wr, byte_acc, step, idx_ok;
  logic match, found_now, miss_now;
  logic [SW-1:0]   wr_pos;
  logic [CMPW-1:0] cnt_ext, len_ext, diff;

  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [EW-1:0]     ram_rdata;
  mbps_pkg::entry_t  wr_entry, ld_entry;

  logic [mbps_pkg::BYTE_W-1:0] win_w [MAX_PATTERN];
  mbps_pkg::entry_t            pat_w [MAX_PATTERN];
  mbps_pkg::cell_ctrl_t        ctrl_w [MAX_PATTERN];
  logic [MAX_PATTERN-1:0]      hit_w;
  logic [MAX_PATTERN-1:0]      act_w;

  // pattern length in use, clamped to the row size
  always_comb begin
    if (int'(len_q) > MAX_PATTERN) begin
      len_eff = LW'(MAX_PATTERN);
    end else begin
      len_eff = LW'(len_q);
    end
    off = LW'(MAX_PATTERN) - len_eff;
  end

  // handshake decode
  assign in_acc   = in_valid_i && !in_stall_o;
  assign pat_wr   = in_acc && (req_type_i == mbps_pkg::REQ_PATTERN);
  assign byte_acc = in_acc && (req_type_i == mbps_pkg::REQ_BYTE);
  assign step     = byte_acc && !done_q;
  assign idx_ok   = int'(pattern_index_i) < MAX_PATTERN;
  assign wr_pos   = SW'(off) + SW'(pattern_index_i);

  // ---------------- reload sequencer ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mbps_pkg::ST_RUN: begin
        if (cfg_we_i) begin
          state_d = mbps_pkg::ST_LOAD;
        end
      end
      mbps_pkg::ST_LOAD: begin
        if (!cfg_we_i && !ld_issue && !ld_pend_q) begin
          state_d = mbps_pkg::ST_RUN;
        end
      end
      default: state_d = mbps_pkg::ST_RUN;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    ld_issue   = 1'b0;
    unique case (state_q)
      mbps_pkg::ST_RUN: begin
        in_stall_o = out_valid_q && out_stall_i;
      end
      mbps_pkg::ST_LOAD: begin
        ld_issue = ld_cnt_q < LW'(MAX_PATTERN);
      end
      default: begin
        in_stall_o = 1'b1;
        ld_issue   = 1'b0;
      end
    endcase
  end

  assign ld_in_win = ld_cnt_q >= off;
  assign ram_raddr = AW'(ld_cnt_q - off);

  always_comb begin
    ld_cnt_d = ld_cnt_q;
    if (cfg_we_i) begin
      ld_cnt_d = '0;
    end else if (ld_issue) begin
      ld_cnt_d = ld_cnt_q + 1'b1;
    end
  end

  // ---------------- entry store ----------------
  assign ram_waddr = AW'(pattern_index_i);
  assign wr_entry  = '{mask: pattern_mask_i, value: pattern_value_i};

  mbps_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_PATTERN)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (pat_wr && idx_ok),
    .waddr_i(ram_waddr),
    .wdata_i(wr_entry),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // never-written entries read as zero
  assign ld_entry = (ld_use_q && ent_vld_rd_q) ? mbps_pkg::entry_t'(ram_rdata) : '0;

  // ---------------- cell row ----------------
  for (genvar m = 0; m < MAX_PATTERN; m++) begin : g_cell
    logic [mbps_pkg::BYTE_W-1:0] win_in;
    mbps_pkg::entry_t            pat_in;

    if (m == MAX_PATTERN - 1) begin : g_top
      assign win_in = data_byte_i;
      assign pat_in = ld_entry;
    end else begin : g_mid
      assign win_in = win_w[m+1];
      assign pat_in = pat_w[m+1];
    end

    assign ctrl_w[m] = '{win_shift: step,
                         pat_shift: ld_pend_q,
                         pat_we:    pat_wr && (wr_pos == SW'(m))};
    assign act_w[m]  = LW'(m) >= off;

    mbps_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl_w[m]),
      .win_i      (win_in),
      .pat_i      (pat_in),
      .pat_wdata_i(wr_entry),
      .win_o      (win_w[m]),
      .pat_o      (pat_w[m]),
      .hit_o      (hit_w[m])
    );
  end

  assign match = &(hit_w | ~act_w);

  // ---------------- search control ----------------
  assign cnt_inc = (count_q == '1) ? count_q : count_q + 1'b1;  // saturating
  assign cnt_ext = CMPW'(cnt_inc);
  assign len_ext = CMPW'(len_eff);
  assign diff    = cnt_ext - len_ext;

  assign found_now = step && (len_eff != '0) && (cnt_ext >= len_ext) && match;
  assign miss_now  = byte_acc && last_byte_i && !done_q && !found_now;

  always_comb begin
    count_d = count_q;
    done_d  = done_q;
    if (byte_acc && last_byte_i) begin
      count_d = '0;
      done_d  = 1'b0;
    end else begin
      if (step) begin
        count_d = cnt_inc;
      end
      if (found_now) begin
        done_d = 1'b1;
      end
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    found_d     = found_q;
    offset_d    = offset_q;
    if (found_now || miss_now) begin
      out_valid_d = 1'b1;
      found_d     = found_now;
      offset_d    = found_now ? mbps_pkg::OFFSET_W'(diff) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mbps_pkg::ST_RUN;
      len_q       <= mbps_pkg::LEN_W'(1);
      ld_cnt_q    <= '0;
      ld_pend_q   <= 1'b0;
      ld_use_q    <= 1'b0;
      ent_vld_q   <= '0;
      count_q     <= '0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ld_cnt_q    <= ld_cnt_d;
      ld_pend_q   <= ld_issue;
      ld_use_q    <= ld_issue && ld_in_win;
      count_q     <= count_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        len_q <= cfg_wdata_i;
      end
      if (pat_wr && idx_ok) begin
        ent_vld_q[ram_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ent_vld_rd_q <= ld_in_win ? ent_vld_q[ram_raddr] : 1'b0;
    found_q      <= found_d;
    offset_q     <= offset_d;
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = found_q;
  assign match_offset_o = offset_q;

endmodule

/* dv/tb_masked_byte_pattern_search.sv */
`timescale 1ns / 100ps

// Self-checking bench for the masked byte pattern search.
// Stimulus runs in two parts. A short directed part covers the wildcard
// reset pattern, zero length, a match completing on the last byte, a pattern
// write in the middle of a buffer, a dead entry and an oversized length.
// A random part follows. It runs in phases. Each phase sets a new pattern
// length and loads a fresh pattern. It then streams buffers, and most of
// them carry a planted occurrence of the pattern.
module tb_masked_byte_pattern_search;

  localparam int NUM_ENTRIES = mbps_pkg::MAX_PATTERN_DEF;
  localparam int CNT_W = mbps_pkg::COUNT_WIDTH_DEF;
  localparam int BYTE_W = mbps_pkg::BYTE_W;
  localparam int IDX_W = mbps_pkg::IDX_W;
  localparam int LEN_W = mbps_pkg::LEN_W;
  localparam int OFFSET_W = mbps_pkg::OFFSET_W;
  localparam int RANDOM_ITEMS = 950;
  localparam int HOLD_CYCLES = 150;      // long receiver hold-off
  localparam int SETTLE_CYCLES = 4;      // result shows in the cycle after its byte
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic                found;
    logic [OFFSET_W-1:0] offset;
  } search_report_t;

  // Tracks the pattern, the sliding byte window and the per-buffer search
  // state. It also queues the reports that the block should produce.
  class search_tracker;
    logic [BYTE_W-1:0] mask_mem [NUM_ENTRIES];
    logic [BYTE_W-1:0] value_mem[NUM_ENTRIES];
    logic [BYTE_W-1:0] history  [NUM_ENTRIES];  // entry 0 is the newest byte
    logic [CNT_W-1:0]  byte_total;
    bit                hit_seen;
    logic [LEN_W-1:0]  length_reg;
    search_report_t    expected_reports[$];
    int                mismatches;

    function new();
      foreach (mask_mem[i]) begin
        mask_mem[i]  = '0;
        value_mem[i] = '0;
      end
      clear_buffer();
      length_reg = LEN_W'(1);
      mismatches = 0;
    endfunction

    function void clear_buffer();
      foreach (history[i]) history[i] = '0;
      byte_total = '0;
      hit_seen = 1'b0;
    endfunction

    // lengths above the store size act as the full store
    function int active_length();
      return (length_reg > NUM_ENTRIES) ? NUM_ENTRIES : int'(length_reg);
    endfunction

    function void note_transaction(logic req, logic [IDX_W-1:0] idx,
                                   logic [BYTE_W-1:0] pmask, pval, data,
                                   logic last_flag);
      int len;
      bit hit;
      if (req == mbps_pkg::REQ_PATTERN) begin
        if (idx < NUM_ENTRIES) begin
          mask_mem[idx]  = pmask;
          value_mem[idx] = pval;
        end
        return;
      end
      len = active_length();
      if (!hit_seen) begin
        for (int i = NUM_ENTRIES - 1; i > 0; i--) history[i] = history[i-1];
        history[0] = data;
        if (byte_total != '1) byte_total++;
        if (len != 0 && byte_total >= len) begin
          hit = 1'b1;
          // entry k lines up with the byte seen len-1-k bytes ago
          for (int k = 0; k < len; k++)
            if ((history[len-1-k] & mask_mem[k]) != value_mem[k]) hit = 1'b0;
          if (hit) begin
            expected_reports.push_back('{found: 1'b1,
                                         offset: OFFSET_W'(byte_total - len)});
            hit_seen = 1'b1;
          end
        end
      end
      if (last_flag) begin
        if (!hit_seen) expected_reports.push_back('{found: 1'b0, offset: '0});
        clear_buffer();
      end
    endfunction

    function void check_report(logic found, logic [OFFSET_W-1:0] offset);
      search_report_t want;
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result found=%0b offset=%0d", $time, found, offset);
        return;
      end
      want = expected_reports.pop_front();
      if (found !== want.found || offset !== want.offset) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"%0t: result mismatch: expected found=%0b offset=%0d, ",
                    "got found=%0b offset=%0d"},
                   $time, want.found, want.offset, found, offset);
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i;
  logic [LEN_W-1:0]    cfg_wdata_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic                req_type_i;
  logic [IDX_W-1:0]    pattern_index_i;
  logic [BYTE_W-1:0]   pattern_mask_i;
  logic [BYTE_W-1:0]   pattern_value_i;
  logic [BYTE_W-1:0]   data_byte_i;
  logic                last_byte_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic                found_o;
  logic [OFFSET_W-1:0] match_offset_o;

  search_tracker tracker;
  int          items_accepted = 0;
  int          burst_left = 0;
  int          holds_requested = 0;   // bumped by the stimulus
  int          holds_served = 0;      // bumped by the receiver
  int unsigned cycle_count = 0;

  masked_byte_pattern_search DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .pattern_index_i (pattern_index_i),
    .pattern_mask_i  (pattern_mask_i),
    .pattern_value_i (pattern_value_i),
    .data_byte_i     (data_byte_i),
    .last_byte_i     (last_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .found_o         (found_o),
    .match_offset_o  (match_offset_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // Output monitor. Values read here are the ones the block saw at this edge,
  // since every driver updates through nonblocking assignments.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      tracker.check_report(found_o, match_offset_o);
  end

  // Receiver. It stalls in modes that each run for a random span: no stall,
  // light random, heavy random and a fixed periodic pattern. A pending hold
  // request preempts the current mode and holds the output for a long hold-off.
  initial begin : receiver
    int span_left;
    int mode;
    int tick;
    span_left = 0;
    mode = 0;
    tick = 0;
    out_stall_i <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (holds_served != holds_requested) begin
        holds_served++;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        if (span_left == 0) begin
          mode = $urandom_range(3, 0);
          span_left = $urandom_range(60, 10);
        end
        span_left--;
        tick++;
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(3, 0) == 0);
          2: out_stall_i <= ($urandom_range(3, 0) != 0);
          default: out_stall_i <= (tick % 3 == 2);
        endcase
        @(posedge clk_i);
      end
    end
  end

  // Offers one transaction and returns at the edge where it is taken. The
  // sender works in bursts. Long bursts give stretches with no idling, and
  // short gaps fall between bursts.
  task automatic send_txn(input logic req, input logic [IDX_W-1:0] idx,
                          input logic [BYTE_W-1:0] pmask, pval, data,
                          input logic last_flag);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(80, 30)
                                               : $urandom_range(12, 1);
      gap = $urandom_range(6, 1);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    burst_left--;
    in_valid_i      <= 1'b1;
    req_type_i      <= req;
    pattern_index_i <= idx;
    pattern_mask_i  <= pmask;
    pattern_value_i <= pval;
    data_byte_i     <= data;
    last_byte_i     <= last_flag;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.note_transaction(req, idx, pmask, pval, data, last_flag);
    items_accepted++;
  endtask

  // the fields that a request does not use carry random values
  task automatic write_entry(input logic [IDX_W-1:0] idx,
                             input logic [BYTE_W-1:0] pmask, pval);
    send_txn(mbps_pkg::REQ_PATTERN, idx, pmask, pval, BYTE_W'($urandom_range(255, 0)),
             1'($urandom_range(1, 0)));
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] data, input logic last_flag);
    send_txn(mbps_pkg::REQ_BYTE, IDX_W'($urandom_range(NUM_ENTRIES - 1, 0)),
             BYTE_W'($urandom_range(255, 0)), BYTE_W'($urandom_range(255, 0)),
             data, last_flag);
  endtask

  // Entry kinds: wildcard, exact byte, partial mask. When allow_dead is set,
  // an entry now and then has value bits outside its mask and never matches.
  task automatic load_random_entry(input int idx, input bit allow_dead);
    logic [BYTE_W-1:0] m;
    logic [BYTE_W-1:0] v;
    m = BYTE_W'($urandom_range(255, 0));
    v = BYTE_W'($urandom_range(255, 0));
    case ($urandom_range(9, 0))
      0, 1, 2: begin
        m = '0;
        v = '0;
      end
      3, 4, 5: m = '1;
      default: v = v & m;
    endcase
    if (allow_dead && $urandom_range(29, 0) == 0) v = v | ~m;
    write_entry(IDX_W'(idx), m, v);
  endtask

  // Streams one buffer. With plant set, the current pattern is placed at a
  // random start when it fits, and unmasked bits get random values. A pattern
  // write lands mid-buffer now and then.
  task automatic send_buffer(input int nbytes, input bit plant);
    logic [BYTE_W-1:0] stream_bytes[64];
    int len;
    int start;
    len = tracker.active_length();
    for (int j = 0; j < nbytes; j++) stream_bytes[j] = BYTE_W'($urandom_range(255, 0));
    if (plant && len != 0 && len <= nbytes) begin
      start = $urandom_range(nbytes - len, 0);
      for (int k = 0; k < len; k++)
        stream_bytes[start+k] = (BYTE_W'($urandom_range(255, 0)) & ~tracker.mask_mem[k]) |
                                (tracker.value_mem[k] & tracker.mask_mem[k]);
    end
    for (int j = 0; j < nbytes; j++) begin
      if ($urandom_range(49, 0) == 0)
        load_random_entry($urandom_range(NUM_ENTRIES - 1, 0), 1'b0);
      send_byte(stream_bytes[j], j == nbytes - 1);
    end
  endtask

  // Stops offering and waits until every queued report has arrived. A settle
  // time follows, because a trailing pattern write gives no report.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (tracker.expected_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // only called while idle; the block reloads its cell row and stalls input
  task automatic write_length(input logic [LEN_W-1:0] len);
    cfg_wdata_i <= len;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    tracker.length_reg = len;
  endtask

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb_masked_byte_pattern_search: done, errors");
    $finish;
  end

  initial begin : stimulus
    int phase;
    int len_sel;
    int eff;
    int nbuf;
    int nbytes;
    int random_start;
    bit pressure;
    tracker = new();
    cfg_we_i        <= 1'b0;
    cfg_wdata_i     <= '0;
    in_valid_i      <= 1'b0;
    req_type_i      <= mbps_pkg::REQ_PATTERN;
    pattern_index_i <= '0;
    pattern_mask_i  <= '0;
    pattern_value_i <= '0;
    data_byte_i     <= '0;
    last_byte_i     <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part.
    // After reset the length is 1 and entry 0 is all zero, so it is a wildcard.
    // The first byte matches. The next byte comes after the match and only
    // closes the buffer.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    wait_idle();
    // zero length never matches
    write_length(LEN_W'(0));
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    wait_idle();
    // The match completes on the last byte. A write past the active length
    // lands mid-buffer and must not disturb the search.
    write_length(LEN_W'(2));
    write_entry(IDX_W'(0), 8'hFF, 8'hA5);
    write_entry(IDX_W'(1), 8'hF0, 8'h30);
    send_byte(8'h00, 1'b0);
    send_byte(8'hA5, 1'b0);
    write_entry(IDX_W'(NUM_ENTRIES - 1), 8'hFF, 8'hFF);
    send_byte(8'h3C, 1'b1);
    wait_idle();
    // a value with bits outside its mask can never match
    write_length(LEN_W'(1));
    write_entry(IDX_W'(0), 8'h0F, 8'hF0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'hFF, 1'b1);
    wait_idle();
    // an oversized length acts as the full store
    write_length('1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);

    // Random part. Each phase waits for the block to go idle. It then sets
    // a new length and loads a fresh pattern. Phase kinds rotate through
    // length 1, the full store, zero, oversized values and small lengths.
    // Some phases send bursts of short buffers while the receiver holds off.
    // This fills the output side and pushes stall back to the input.
    phase = 0;
    random_start = items_accepted;
    while (items_accepted - random_start < RANDOM_ITEMS) begin
      case (phase % 8)
        0: len_sel = 1;
        1: len_sel = NUM_ENTRIES;
        2: len_sel = 0;
        3: len_sel = (phase == 3) ? 63 : $urandom_range(63, NUM_ENTRIES + 1);
        default: len_sel = $urandom_range(8, 2);
      endcase
      wait_idle();
      write_length(LEN_W'(len_sel));
      eff = tracker.active_length();
      for (int e = 0; e < ((eff == 0) ? 3 : eff); e++)
        load_random_entry(e, eff <= 8);
      pressure = (phase % 6 == 4);
      if (pressure) holds_requested++;
      nbuf = pressure ? 16 : $urandom_range(8, 4);
      repeat (nbuf) begin
        if (pressure) nbytes = $urandom_range(3, 1);
        else if ($urandom_range(9, 0) == 0) nbytes = $urandom_range(64, 1);
        else nbytes = $urandom_range(eff + 10, 1);
        send_buffer(nbytes, $urandom_range(9, 0) < 7);
      end
      phase++;
    end

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (tracker.expected_reports.size() != 0) tracker.mismatches++;
    if (tracker.mismatches == 0) begin
      $display("tb_masked_byte_pattern_search: done, clean");
    end else begin
      $display("tb_masked_byte_pattern_search: done, errors");
    end
    $finish;
  end

endmodule
